>>> hdl/csca_pkg.sv
// Shared types and constants for the chunk slot cache allocator.
package csca_pkg;

    // Fixed field widths of the item ports.
    localparam int COORD_W = 6;
    localparam int POS_W   = 3 * COORD_W;
    localparam int SLOT_W  = 5;
    localparam int ADDR_W  = 18;
    localparam int OFFS_W  = 15;

    // Upper bound on upload results produced by a single prepare request.
    localparam int MAX_OUT = 32;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // Request codes.
    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_PREPARE = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_UPLOAD = 2'd3
    } t_kind;

    // Input item.
    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
    } t_in_item;

    // Result item.
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  location_address;
        logic [OFFS_W-1:0]  data_offset;
        logic               last;
    } t_out_item;

endpackage

>>> hdl/csca_pos_ram.sv
// Position store: one write port and one registered read port.
module csca_pos_ram #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [csca_pkg::POS_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [csca_pkg::POS_W-1:0]        o_rdata
);
    import csca_pkg::*;

    logic [POS_W-1:0] r_mem [DEPTH];
    logic [POS_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/chunk_slot_cache_allocator_unit.sv
// Chunk slot cache allocator: position table with a sequential slot scan.
// Each request scans the slots one per cycle through the position RAM read port, but a
//   prepare scan waits while a result holds the output. Add: result registered at the end
//   of the scan (earlier on a hit); the next item is accepted only after the result is produced.
// Prepare: a result waiting on the output stalls the scan or flush when another upload is due.
// Reset clears the valid and uploaded flags at once; the position RAM is not cleared.
module chunk_slot_cache_allocator_unit #(
    parameter int SLOTS      = 32,
    parameter int AXIS_SIZE  = 64,
    parameter int SLOT_WORDS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  csca_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output csca_pkg::t_out_item   o_out_item
);
    import csca_pkg::*;

    localparam int             IW       = $clog2(SLOTS);
    localparam logic [IW-1:0]  LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Linear location-map address of a grid position.
    function automatic logic [ADDR_W-1:0] f_grid_addr(input logic [POS_W-1:0] pos);
        logic [31:0] s;
        s = 32'(pos[COORD_W-1:0])
            + 32'(pos[2*COORD_W-1:COORD_W]) * 32'(AXIS_SIZE)
            + 32'(pos[3*COORD_W-1:2*COORD_W]) * 32'(AXIS_SIZE * AXIS_SIZE);
        return s[ADDR_W-1:0];
    endfunction

    // Word offset of a slot's chunk data.
    function automatic logic [OFFS_W-1:0] f_offset(input logic [IW-1:0] idx);
        logic [39:0] p;
        p = 40'(idx) * 40'(SLOT_WORDS);
        return p[OFFS_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [IW-1:0]      r_idx, n_idx;
    t_in_item           r_req, n_req;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic               r_cand_vld, n_cand_vld;
    logic [IW-1:0]      r_cand_idx, n_cand_idx;
    logic [POS_W-1:0]   r_cand_pos, n_cand_pos;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [SLOTS-1:0]   r_valid;
    logic [SLOTS-1:0]   r_upl;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               out_free;
    logic [POS_W-1:0]   pos_q;
    logic [POS_W-1:0]   req_key;
    logic               hit;
    logic               pend;
    logic               at_end;
    logic               any_free;
    logic [IW-1:0]      sel_free_idx;
    logic               emit;
    t_out_item          emit_item;
    logic               do_alloc;
    logic               do_mark;

    // Position RAM, read one slot ahead of the compare.
    csca_pos_ram #(
        .DEPTH (SLOTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (do_alloc),
        .i_waddr (sel_free_idx),
        .i_wdata (req_key),
        .i_raddr (n_idx),
        .o_rdata (pos_q)
    );

    // Per-slot compare terms.
    assign out_free     = !r_out_valid || i_out_ready;
    assign req_key      = {r_req.pos_z, r_req.pos_y, r_req.pos_x};
    assign hit          = r_valid[r_idx] && (pos_q == req_key);
    assign pend         = r_valid[r_idx] && !r_upl[r_idx];
    assign at_end       = (r_idx == LAST_IDX);
    assign any_free     = r_free_found || !r_valid[r_idx];
    assign sel_free_idx = r_free_found ? r_free_idx : r_idx;

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cand_vld   = r_cand_vld;
        n_cand_idx   = r_cand_idx;
        n_cand_pos   = r_cand_pos;
        n_n          = r_n;
        emit         = 1'b0;
        emit_item    = '0;
        do_alloc     = 1'b0;
        do_mark      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_in_item;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_cand_vld   = 1'b0;
                    n_n          = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_req.req_type == REQ_ADD) begin
                    // Search for a match while remembering the lowest free slot.
                    if (hit) begin
                        if (out_free) begin
                            emit                       = 1'b1;
                            emit_item.kind             = KIND_HIT;
                            emit_item.slot             = SLOT_W'(r_idx);
                            emit_item.location_address = f_grid_addr(req_key);
                            emit_item.data_offset      = f_offset(r_idx);
                            emit_item.last             = 1'b1;
                            n_state                    = S_IDLE;
                        end
                    end else if (at_end) begin
                        if (out_free) begin
                            emit                       = 1'b1;
                            emit_item.location_address = f_grid_addr(req_key);
                            emit_item.last             = 1'b1;
                            if (any_free) begin
                                do_alloc              = 1'b1;
                                emit_item.kind        = KIND_NEW;
                                emit_item.slot        = SLOT_W'(sel_free_idx);
                                emit_item.data_offset = f_offset(sel_free_idx);
                            end else begin
                                emit_item.kind        = KIND_FULL;
                            end
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                        if (!r_free_found && !r_valid[r_idx]) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_idx;
                        end
                    end
                end else begin
                    // Hold one pending slot back so the final result can carry last.
                    if (r_cand_vld && (r_n == CNT_W'(MAX_OUT))) begin
                        n_state = S_FLUSH;
                    end else if (pend && r_cand_vld && !out_free) begin
                        n_state = S_SCAN;
                    end else begin
                        if (pend) begin
                            if (r_cand_vld) begin
                                emit                       = 1'b1;
                                emit_item.kind             = KIND_UPLOAD;
                                emit_item.slot             = SLOT_W'(r_cand_idx);
                                emit_item.location_address = f_grid_addr(r_cand_pos);
                                emit_item.data_offset      = f_offset(r_cand_idx);
                                emit_item.last             = 1'b0;
                            end
                            do_mark    = 1'b1;
                            n_cand_vld = 1'b1;
                            n_cand_idx = r_idx;
                            n_cand_pos = pos_q;
                            n_n        = r_n + CNT_W'(1);
                        end
                        if (at_end) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!r_cand_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    emit                       = 1'b1;
                    emit_item.kind             = KIND_UPLOAD;
                    emit_item.slot             = SLOT_W'(r_cand_idx);
                    emit_item.location_address = f_grid_addr(r_cand_pos);
                    emit_item.data_offset      = f_offset(r_cand_idx);
                    emit_item.last             = 1'b1;
                    n_cand_vld                 = 1'b0;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, slot flags and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_upl       <= '0;
            r_out_valid <= 1'b0;
            r_cand_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cand_vld <= n_cand_vld;
            if (do_alloc) begin
                r_valid[sel_free_idx] <= 1'b1;
                r_upl[sel_free_idx]   <= 1'b0;
            end
            if (do_mark) begin
                r_upl[r_idx] <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_idx        <= n_idx;
        r_req        <= n_req;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_cand_idx   <= n_cand_idx;
        r_cand_pos   <= n_cand_pos;
        r_n          <= n_n;
        if (emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/csca_checker.sv
// Port-level assertions for the chunk slot cache allocator, bound to the top level.
module csca_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  csca_pkg::t_in_item    i_in_item,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  csca_pkg::t_out_item   o_out_item
);
    import csca_pkg::*;

    // An offered item holds steady until it is accepted.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input item changed or dropped while waiting");

    // A result waiting on the output holds steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed or dropped while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an item was accepted");

    // Every add result is the only result of its request.
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind != KIND_UPLOAD)) |-> o_out_item.last)
        else $error("add result without last");

    // A full table answers with slot zero and offset zero.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == KIND_FULL))
        |-> ((o_out_item.slot == '0) && (o_out_item.data_offset == '0)))
        else $error("table full result carries a slot");

endmodule

bind chunk_slot_cache_allocator_unit csca_checker u_csca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> test/tb_top.sv
// Self-checking testbench for the chunk slot cache allocator unit.
`timescale 1ns / 100ps

module tb_top;
    import csca_pkg::*;

    localparam int SLOTS       = 32;
    localparam int AXIS        = 64;
    localparam int SLOT_WORDS  = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = SLOTS + 8;

    // Traffic phases: which side inserts gaps, and the long output hold-off.
    typedef enum int {
        PH_FREE,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH_GAPS,
        PH_BACKPRESSURE
    } t_phase;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_phase phase = PH_FREE;

    // Requests waiting to be offered, and results the table model predicts.
    t_in_item          pending_q[$];
    t_out_item         result_q[$];
    logic [POS_W-1:0]  sent_pos[$];

    // Model of the slot table.
    logic              slot_used[SLOTS];
    logic              slot_sent[SLOTS];
    logic [POS_W-1:0]  slot_key[SLOTS];

    int hold_left    = 0;
    bit hold_started = 1'b0;

    int mismatches      = 0;
    int results_checked = 0;
    int adds_seen       = 0;
    int prepares_seen   = 0;
    int hits_seen       = 0;
    int fulls_seen      = 0;
    int uploads_seen    = 0;

    t_out_item got_item;

    chunk_slot_cache_allocator_unit #(
        .SLOTS      (SLOTS),
        .AXIS_SIZE  (AXIS),
        .SLOT_WORDS (SLOT_WORDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [POS_W-1:0] key);
        int unsigned a;
        a = 32'(key[5:0]) + 32'(key[11:6]) * AXIS + 32'(key[17:12]) * AXIS * AXIS;
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [OFFS_W-1:0] slot_offset(input int slot);
        int unsigned o;
        o = 32'(slot) * SLOT_WORDS;
        return o[OFFS_W-1:0];
    endfunction

    // Work out the results one accepted request causes and update the table.
    task automatic predict(input t_in_item it);
        logic [POS_W-1:0] key;
        int               free_slot;
        int               hit_slot;
        int               total;
        int               n;
        t_out_item        r;
        key = {it.pos_z, it.pos_y, it.pos_x};
        if (it.req_type == REQ_ADD) begin
            adds_seen++;
            free_slot = -1;
            hit_slot  = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_used[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (slot_key[i] == key && hit_slot < 0) begin
                    hit_slot = i;
                end
            end
            r.location_address = grid_addr(key);
            r.last             = 1'b1;
            if (hit_slot >= 0) begin
                hits_seen++;
                r.kind        = KIND_HIT;
                r.slot        = hit_slot[SLOT_W-1:0];
                r.data_offset = slot_offset(hit_slot);
            end else if (free_slot < 0) begin
                fulls_seen++;
                r.kind        = KIND_FULL;
                r.slot        = '0;
                r.data_offset = '0;
            end else begin
                r.kind              = KIND_NEW;
                r.slot              = free_slot[SLOT_W-1:0];
                r.data_offset       = slot_offset(free_slot);
                slot_used[free_slot] = 1'b1;
                slot_sent[free_slot] = 1'b0;
                slot_key[free_slot]  = key;
            end
            result_q.push_back(r);
        end else begin
            prepares_seen++;
            // Count the pending slots first so the final upload carries last.
            total = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && !slot_sent[i]) total++;
            end
            if (total > MAX_OUT) total = MAX_OUT;
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && !slot_sent[i] && n < total) begin
                    r.kind             = KIND_UPLOAD;
                    r.slot             = i[SLOT_W-1:0];
                    r.location_address = grid_addr(slot_key[i]);
                    r.data_offset      = slot_offset(i);
                    r.last             = (n == total - 1);
                    slot_sent[i]       = 1'b1;
                    result_q.push_back(r);
                    uploads_seen++;
                    n++;
                end
            end
        end
    endtask

    // Driver: offer the next pending item, holding it until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_sent[i] = 1'b0;
                slot_key[i]  = '0;
            end
        end else begin
            if (i_in_valid && o_in_ready) predict(i_in_item);
            if (!i_in_valid || o_in_ready) begin
                if (pending_q.size() != 0 &&
                    !roll(phase == PH_SEND_GAPS ? 52 : (phase == PH_BOTH_GAPS ? 7 : 0))) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, started once when the backpressure phase begins.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else if (phase == PH_BACKPRESSURE && !hold_started) begin
            hold_left    <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (hold_left == 0) &&
                !roll(phase == PH_RECV_STALLS ? 52 : (phase == PH_BOTH_GAPS ? 7 : 0));
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_item = o_out_item;
            if (result_q.size() == 0) begin
                $error("unexpected result item: kind %0d slot %0d addr 0x%0h",
                       got_item.kind, got_item.slot, got_item.location_address);
                mismatches++;
            end else begin
                t_out_item want;
                want = result_q.pop_front();
                check_field("kind", want.kind, got_item.kind);
                check_field("slot", want.slot, got_item.slot);
                check_field("location_address", want.location_address,
                            got_item.location_address);
                check_field("data_offset", want.data_offset, got_item.data_offset);
                check_field("last", want.last, got_item.last);
                results_checked++;
            end
        end
    end

    task automatic queue_request(input logic req, input logic [COORD_W-1:0] x,
                                 input logic [COORD_W-1:0] y,
                                 input logic [COORD_W-1:0] z);
        t_in_item it;
        it.req_type = req;
        it.pos_x    = x;
        it.pos_y    = y;
        it.pos_z    = z;
        if (req == REQ_ADD) sent_pos.push_back({z, y, x});
        pending_q.push_back(it);
    endtask

    // Mostly adds, a good share of them repeating a position already sent.
    task automatic queue_random(input int count);
        int unsigned      pick;
        logic [POS_W-1:0] p;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            p    = POS_W'($urandom);
            if (pick < 15) begin
                queue_request(REQ_PREPARE, p[5:0], p[11:6], p[17:12]);
            end else begin
                if (pick < 45 && sent_pos.size() != 0)
                    p = sent_pos[$urandom_range(sent_pos.size() - 1)];
                queue_request(REQ_ADD, p[5:0], p[11:6], p[17:12]);
            end
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || i_in_valid || result_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: empty prepare, corner positions, hits, uploads.
        phase = PH_FREE;
        queue_request(REQ_PREPARE, 6'd63, 6'd63, 6'd63);
        queue_request(REQ_ADD, 6'd0, 6'd0, 6'd0);
        queue_request(REQ_ADD, 6'd0, 6'd0, 6'd0);
        queue_request(REQ_ADD, 6'd63, 6'd63, 6'd63);
        queue_request(REQ_ADD, 6'd63, 6'd0, 6'd0);
        queue_request(REQ_ADD, 6'd0, 6'd63, 6'd0);
        queue_request(REQ_ADD, 6'd0, 6'd0, 6'd63);
        queue_request(REQ_ADD, 6'd63, 6'd63, 6'd63);
        queue_request(REQ_PREPARE, 6'd0, 6'd0, 6'd0);
        queue_request(REQ_PREPARE, 6'd21, 6'd42, 6'd7);
        queue_request(REQ_ADD, 6'd1, 6'd2, 6'd3);
        queue_request(REQ_PREPARE, 6'd0, 6'd0, 6'd0);
        queue_request(REQ_ADD, 6'd0, 6'd0, 6'd63);
        drain();

        // Random phases; the hold-off comes first while slots are still free.
        phase = PH_BACKPRESSURE;
        queue_random(30);
        drain();
        phase = PH_FREE;
        queue_random(45);
        drain();
        phase = PH_SEND_GAPS;
        queue_random(45);
        drain();
        phase = PH_RECV_STALLS;
        queue_random(45);
        drain();
        phase = PH_BOTH_GAPS;
        queue_random(45);
        drain();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Covered %0d adds (%0d hits, %0d table full) and %0d prepares.",
                 adds_seen, hits_seen, fulls_seen, prepares_seen);
        $display("Checked %0d result items, %0d of them uploads, under gaps and stalls.",
                 results_checked, uploads_seen);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/csca_pkg.sv
hdl/csca_pos_ram.sv
hdl/chunk_slot_cache_allocator_unit.sv
hdl/csca_checker.sv
test/tb_top.sv
